/* sv/pls_pkg.sv */
`timescale 1ns / 1ps
// Package for the positional list store: sizes, operation codes and the
// request, response and internal control types. No dependencies.
package pls_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int POS_W      = 5;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic                   from_tail;
      logic [POS_W-1:0]       position;
      logic [DATA_WIDTH-1:0]  data_in;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [DATA_WIDTH-1:0]  data_out;
      logic [CNT_W-1:0]       count;
      logic                   is_empty;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                   ins;
      logic                   rem;
      logic [IDX_W-1:0]       idx;
      logic [DATA_WIDTH-1:0]  data;
   } cmd_type;

   // Outcome of one request, as seen by the response path.
   typedef struct packed {
      logic                   ok;
      logic                   take_data;
      logic [CNT_W-1:0]       next_count;
   } stat_type;

endpackage

/* sv/pls_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the list row. It shifts toward either neighbor or
// takes new data as the broadcast command says. Depends on pls_pkg.
module pls_cell (
   input  logic                               clock,
   input  logic                               fire,
   input  pls_pkg::cmd_type                   cmd,
   input  logic [pls_pkg::IDX_W-1:0]          cell_index,
   input  logic [pls_pkg::DATA_WIDTH-1:0]     lower_data,
   input  logic [pls_pkg::DATA_WIDTH-1:0]     upper_data,
   output logic [pls_pkg::DATA_WIDTH-1:0]     cell_data,
   output logic [pls_pkg::DATA_WIDTH-1:0]     tap_data
);

   logic [pls_pkg::DATA_WIDTH-1:0] data_ff;
   logic [pls_pkg::DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (cell_index == cmd.idx) begin
            data_in = cmd.data;
         end else if (cell_index > cmd.idx) begin
            data_in = lower_data;
         end
      end else if (cmd.rem && (cell_index >= cmd.idx)) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= data_in;
      end
   end

   assign cell_data = data_ff;
   // Only the addressed cell drives the read bus; the rest give zero.
   assign tap_data  = (cell_index == cmd.idx) ? data_ff : '0;

endmodule

/* sv/pls_ctrl.sv */
`timescale 1ns / 1ps
// Request decoder and element counter for the positional list store.
// Checks the request against the count and drives the cell row. Depends on pls_pkg.
module pls_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  pls_pkg::req_type    req,
   output pls_pkg::cmd_type    cmd,
   output pls_pkg::stat_type   stat
);

   logic [pls_pkg::CNT_W-1:0] count_ff;
   logic [pls_pkg::CNT_W-1:0] count_in;
   logic [pls_pkg::CMP_W-1:0] cnt_c;
   logic [pls_pkg::CMP_W-1:0] pos_c;
   logic                      ok;

   always_comb begin
      cnt_c    = pls_pkg::CMP_W'(count_ff);
      pos_c    = pls_pkg::CMP_W'(req.position);
      ok       = 1'b0;
      count_in = count_ff;
      cmd      = '0;
      cmd.data = req.data_in;
      stat     = '0;
      unique case (req.mode)
         pls_pkg::MODE_INSERT: begin
            if (req.from_tail) begin
               pos_c = cnt_c;
            end
            ok = (count_ff < pls_pkg::CNT_W'(pls_pkg::DEPTH)) && (pos_c <= cnt_c);
            if (ok) begin
               count_in = count_ff + 1'b1;
            end
         end
         pls_pkg::MODE_REMOVE, pls_pkg::MODE_READ: begin
            if (req.from_tail) begin
               pos_c = cnt_c - 1'b1;
            end
            ok = (count_ff != '0) && (pos_c < cnt_c);
            if (ok && (req.mode == pls_pkg::MODE_REMOVE)) begin
               count_in = count_ff - 1'b1;
            end
            stat.take_data = ok;
         end
         pls_pkg::MODE_CLEAR: begin
            ok       = 1'b1;
            count_in = '0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      cmd.idx         = pos_c[pls_pkg::IDX_W-1:0];
      cmd.ins         = fire && ok && (req.mode == pls_pkg::MODE_INSERT);
      cmd.rem         = fire && ok && (req.mode == pls_pkg::MODE_REMOVE);
      stat.ok         = ok;
      stat.next_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/positional_list_store_top.sv */
`timescale 1ns / 1ps
// Top level of the positional list store: request and response channels,
// the cell row and the response register. Depends on pls_pkg, pls_ctrl, pls_cell.
//
// Usage:
//   A request carries a mode (insert, remove, read, clear all), a from_tail
//   flag, a position counted from the head and the element to insert. Each
//   request yields exactly one response with a success flag, the element
//   removed or read (zero otherwise), the count after the operation and an
//   empty flag. Failed requests change nothing.
//   The response is valid in the cycle after the request is accepted. One
//   request is taken per cycle unless a stalled response holds it off, since
//   the cells from the position upward shift toward their neighbors in parallel
//   in the accepting cycle; the read path is a one-hot selection across the row.
//   While a response waits for rsp_ready, req_ready stays high only if the
//   response register is being emptied in the same cycle, so a stalled
//   receiver holds the list and the pending response unchanged.
//   Reset empties the list (count zero) and drops any pending response; the
//   cell contents are not cleared and are only read after being written.
module positional_list_store_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pls_pkg::req_type   req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pls_pkg::rsp_type   rsp_payload
);

   logic                                    fire;
   pls_pkg::cmd_type                        cmd;
   pls_pkg::stat_type                       stat;
   logic [pls_pkg::DATA_WIDTH-1:0]          cell_data [pls_pkg::DEPTH];
   logic [pls_pkg::DATA_WIDTH-1:0]          tap_data  [pls_pkg::DEPTH];
   logic [pls_pkg::DATA_WIDTH-1:0]          read_data;
   logic                                    rsp_valid_ff;
   pls_pkg::rsp_type                        rsp_ff;
   pls_pkg::rsp_type                        rsp_in;

   // No request is taken while reset is held.
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign fire      = req_valid && req_ready;

   pls_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_payload),
      .cmd   (cmd),
      .stat  (stat)
   );

   for (genvar i = 0; i < pls_pkg::DEPTH; i++) begin : g_cell
      logic [pls_pkg::DATA_WIDTH-1:0] lower_data;
      logic [pls_pkg::DATA_WIDTH-1:0] upper_data;

      if (i == 0) begin : g_first
         assign lower_data = '0;
      end else begin : g_mid_lo
         assign lower_data = cell_data[i-1];
      end
      if (i == pls_pkg::DEPTH - 1) begin : g_last
         assign upper_data = '0;
      end else begin : g_mid_hi
         assign upper_data = cell_data[i+1];
      end

      pls_cell u_cell (
         .clock      (clock),
         .fire       (fire),
         .cmd        (cmd),
         .cell_index (pls_pkg::IDX_W'(i)),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .cell_data  (cell_data[i]),
         .tap_data   (tap_data[i])
      );
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < pls_pkg::DEPTH; i++) begin
         read_data = read_data | tap_data[i];
      end
   end

   always_comb begin
      rsp_in.ok       = stat.ok;
      rsp_in.data_out = stat.take_data ? read_data : '0;
      rsp_in.count    = stat.next_count;
      rsp_in.is_empty = (stat.next_count == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* sv/pls_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store_top.
module pls_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  pls_pkg::rsp_type   rsp_payload
);

   // A stalled response must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every accepted request shows a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.count == '0)))
      else $error("empty flag disagrees with count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.count <= pls_pkg::CNT_W'(pls_pkg::DEPTH)))
      else $error("count exceeds capacity");

   // A failed request never returns an element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.ok |-> (rsp_payload.data_out == '0))
      else $error("failed request returned data");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* tb/tb_positional_list_store_top.sv */
`timescale 1ns / 1ps
// Testbench for positional_list_store_top: drives random and directed list requests
// and checks every response against its own list predictor. Depends on pls_pkg.
module tb_positional_list_store_top;

   localparam int RANDOM_ITEMS = 1230;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;

   // Tracks the list contents as the block should hold them and queues the
   // response each accepted request must produce.
   class list_scoreboard;
      logic [pls_pkg::DATA_WIDTH-1:0] cells [pls_pkg::DEPTH];
      int                             elements;
      pls_pkg::rsp_type               expected_rsps [$];
      int                             mismatches;

      function new();
         elements   = 0;
         mismatches = 0;
      endfunction

      function int stored_count();
         return elements;
      endfunction

      function int pending_rsps();
         return expected_rsps.size();
      endfunction

      function pls_pkg::rsp_type predict_list_op(pls_pkg::req_type r);
         pls_pkg::rsp_type e;
         int               at;
         e = '0;
         case (r.mode)
            pls_pkg::MODE_INSERT: begin
               at = r.from_tail ? elements : int'(r.position);
               if (elements < pls_pkg::DEPTH && at <= elements) begin
                  for (int i = elements; i > at; i--) cells[i] = cells[i-1];
                  cells[at] = r.data_in;
                  elements++;
                  e.ok = 1'b1;
               end
            end
            pls_pkg::MODE_REMOVE, pls_pkg::MODE_READ: begin
               if (elements > 0) begin
                  at = r.from_tail ? elements - 1 : int'(r.position);
                  if (at < elements) begin
                     e.data_out = cells[at];
                     if (r.mode == pls_pkg::MODE_REMOVE) begin
                        for (int i = at; i + 1 < elements; i++) cells[i] = cells[i+1];
                        elements--;
                     end
                     e.ok = 1'b1;
                  end
               end
            end
            default: begin
               elements = 0;
               e.ok     = 1'b1;
            end
         endcase
         e.count    = elements[pls_pkg::CNT_W-1:0];
         e.is_empty = (elements == 0);
         return e;
      endfunction

      function void note_request(pls_pkg::req_type r);
         expected_rsps.push_back(predict_list_op(r));
      endfunction

      function void check_response(pls_pkg::rsp_type a);
         pls_pkg::rsp_type e;
         if (expected_rsps.size() == 0) begin
            $error("response with no request outstanding: %h", a);
            mismatches++;
            return;
         end
         e = expected_rsps.pop_front();
         if (a.ok !== e.ok) begin
            $error("ok: expected %0d, got %0d", e.ok, a.ok);
            mismatches++;
         end
         if (a.data_out !== e.data_out) begin
            $error("data_out: expected %h, got %h", e.data_out, a.data_out);
            mismatches++;
         end
         if (a.count !== e.count) begin
            $error("count: expected %0d, got %0d", e.count, a.count);
            mismatches++;
         end
         if (a.is_empty !== e.is_empty) begin
            $error("is_empty: expected %0d, got %0d", e.is_empty, a.is_empty);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   pls_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   pls_pkg::rsp_type rsp_payload;

   list_scoreboard sb = new();
   int             n_accepted = 0;

   positional_list_store_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else return $urandom_range(6, 40);
   endfunction

   function automatic pls_pkg::req_type list_req(pls_pkg::mode_type m, logic tail, int at,
                                                 logic [pls_pkg::DATA_WIDTH-1:0] value);
      pls_pkg::req_type r;
      r.mode      = m;
      r.from_tail = tail;
      r.position  = at[pls_pkg::POS_W-1:0];
      r.data_in   = value;
      return r;
   endfunction

   // Most positions land inside the legal range for the current length so the
   // list grows and shrinks; a share is drawn over the whole field.
   function automatic pls_pkg::req_type make_request(int ins_pct);
      pls_pkg::req_type r;
      int               roll;
      int               len;
      len         = sb.stored_count();
      roll        = $urandom_range(0, 99);
      r.data_in   = $urandom;
      r.from_tail = ($urandom_range(0, 3) == 0);
      r.position  = '0;
      if ($urandom_range(0, 99) == 0) r.mode = pls_pkg::MODE_CLEAR;
      else if (roll < ins_pct) r.mode = pls_pkg::MODE_INSERT;
      else if (roll < ins_pct + (100 - ins_pct) / 2) r.mode = pls_pkg::MODE_REMOVE;
      else r.mode = pls_pkg::MODE_READ;
      if ($urandom_range(0, 99) < 12) begin
         r.position = pls_pkg::POS_W'($urandom_range(0, 31));
      end else if (r.mode == pls_pkg::MODE_INSERT) begin
         r.position = pls_pkg::POS_W'($urandom_range(0, len));
      end else if (len > 0) begin
         r.position = pls_pkg::POS_W'($urandom_range(0, len - 1));
      end
      return r;
   endfunction

   task automatic send_request(input pls_pkg::req_type r);
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      n_accepted++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_rsps() != 0);
   endtask

   initial begin : req_side
      pls_pkg::req_type directed [$];
      pls_pkg::req_type r;
      int               n;
      int               seg_left;
      int               ins_pct;
      bit               steady;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty-list failures, out-of-range positions, both ends, the middle,
      // and a clear with every ignored field set.
      directed.push_back(list_req(pls_pkg::MODE_REMOVE, 1'b0, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_READ, 1'b1, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_REMOVE, 1'b1, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_INSERT, 1'b0, 1, 32'h1234_5678));
      directed.push_back(list_req(pls_pkg::MODE_INSERT, 1'b0, 0, 32'hFFFF_FFFF));
      directed.push_back(list_req(pls_pkg::MODE_INSERT, 1'b1, 31, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_INSERT, 1'b0, 1, 32'hA5A5_5A5A));
      directed.push_back(list_req(pls_pkg::MODE_INSERT, 1'b0, 31, 32'h5555_AAAA));
      directed.push_back(list_req(pls_pkg::MODE_READ, 1'b0, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_READ, 1'b1, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_READ, 1'b0, 3, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_READ, 1'b0, 31, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_REMOVE, 1'b0, 1, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_REMOVE, 1'b1, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_CLEAR, 1'b1, 31, 32'hFFFF_FFFF));
      directed.push_back(list_req(pls_pkg::MODE_INSERT, 1'b1, 0, 32'h0000_0001));
      directed.push_back(list_req(pls_pkg::MODE_READ, 1'b0, 0, 32'h0));
      directed.push_back(list_req(pls_pkg::MODE_REMOVE, 1'b0, 0, 32'h0));
      foreach (directed[i]) begin
         send_request(directed[i]);
         idle_sender(pick_gap());
      end
      wait_for_drain();

      // Segments lean toward growing, shrinking or mixing so that the list
      // reaches both full and empty again and again.
      n        = 0;
      seg_left = 0;
      ins_pct  = 45;
      steady   = 1'b0;
      while (n < RANDOM_ITEMS) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0:       ins_pct = 75;
               1:       ins_pct = 20;
               default: ins_pct = 45;
            endcase
            steady = ($urandom_range(0, 3) == 0);
         end
         r = make_request(ins_pct);
         send_request(r);
         n++;
         seg_left--;
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         else if (!steady) idle_sender(pick_gap());
      end
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsps() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : rsp_side
      int  hold;
      bit  held_off;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && n_accepted >= HOLD_AT) begin
            // Long back-pressure while the sender keeps offering requests.
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            hold = 0;
            while (hold < HOLD_CYCLES) begin
               @(posedge clock);
               hold++;
            end
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(30, 120)) @(posedge clock);
         end else begin
            hold = pick_gap();
            if (hold > 0) begin
               rsp_ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
sv/pls_pkg.sv
sv/pls_cell.sv
sv/pls_ctrl.sv
sv/positional_list_store_top.sv
sv/pls_checker.sv
tb/tb_positional_list_store_top.sv
